[sv/flvthf_pkg.sv]
// Shared types and constants for the FLV tag header framer.
`default_nettype none
package flvthf_pkg;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_MEDIA = 2'd1,
    FUNC_DATA  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam int FRAME_BYTES   = 15;
  localparam int LEN_W         = 4;
  localparam int FILE_HDR_LEN  = 9;
  localparam int TAG_HDR_LEN   = 11;

  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_L        = 8'h4C;
  localparam logic [7:0] CH_V        = 8'h56;
  localparam logic [7:0] FLV_VERSION = 8'h01;
  localparam logic [7:0] FILE_HDR_SZ = 8'h09;

  typedef struct packed {
    func_t        func;
    logic [7:0]   tag_type;
    logic [23:0]  payload_size;
    logic [31:0]  stamp_in;
    logic         has_audio;
    logic         has_video;
  } in_item_t;

  // Byte 0 goes out first.
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]            len;
  } frame_t;

endpackage
`default_nettype wire

[sv/flvthf_if.sv]
// Valid/ready channel interfaces for requests and result bytes.
`default_nettype none
interface flvthf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  tag_type;
  logic [23:0] payload_size;
  logic [31:0] stamp_in;
  logic        has_audio;
  logic        has_video;

  modport source (output valid, func, tag_type, payload_size, stamp_in, has_audio, has_video,
                  input ready);
  modport sink (input valid, func, tag_type, payload_size, stamp_in, has_audio, has_video,
                output ready);
endinterface

interface flvthf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface
`default_nettype wire

[sv/flvthf_build.sv]
// Frame builder: timestamp rebasing, previous-size tracking and byte layout.
`default_nettype none
module flvthf_build (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire flvthf_pkg::in_item_t item,
  output flvthf_pkg::frame_t      frame
);
  import flvthf_pkg::*;

  logic [31:0] running_prev_size;
  logic [31:0] first_stamp [2];

  logic        idx;
  logic [31:0] stored;
  logic [31:0] base;
  logic        in_order;
  logic [31:0] ts;
  logic [7:0]  flags;

  assign idx      = item.tag_type[0];
  assign stored   = first_stamp[idx];
  // Unset entry takes this stamp as its base.
  assign base     = (stored == 32'd0) ? item.stamp_in : stored;
  assign in_order = item.stamp_in >= base;
  assign flags    = {5'd0, item.has_audio, 1'b0, item.has_video};

  always_comb begin
    ts = item.stamp_in;
    if (item.func == FUNC_MEDIA) begin
      ts = in_order ? (item.stamp_in - base) : 32'd0;
    end
  end

  always_comb begin
    frame.bytes = '0;
    frame.len   = '0;
    case (item.func)
      FUNC_START: begin
        frame.bytes[0] = CH_F;
        frame.bytes[1] = CH_L;
        frame.bytes[2] = CH_V;
        frame.bytes[3] = FLV_VERSION;
        frame.bytes[4] = flags;
        frame.bytes[8] = FILE_HDR_SZ;
        frame.len      = LEN_W'(FILE_HDR_LEN);
      end
      FUNC_MEDIA, FUNC_DATA: begin
        frame.bytes[0]  = running_prev_size[31:24];
        frame.bytes[1]  = running_prev_size[23:16];
        frame.bytes[2]  = running_prev_size[15:8];
        frame.bytes[3]  = running_prev_size[7:0];
        frame.bytes[4]  = item.tag_type;
        frame.bytes[5]  = item.payload_size[23:16];
        frame.bytes[6]  = item.payload_size[15:8];
        frame.bytes[7]  = item.payload_size[7:0];
        frame.bytes[8]  = ts[23:16];
        frame.bytes[9]  = ts[15:8];
        frame.bytes[10] = ts[7:0];
        frame.bytes[11] = ts[31:24];
        frame.len       = LEN_W'(FRAME_BYTES);
      end
      default: begin
        frame.len = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_prev_size <= '0;
      first_stamp[0]    <= '0;
      first_stamp[1]    <= '0;
    end else if (load) begin
      case (item.func)
        FUNC_START: begin
          running_prev_size <= '0;
          first_stamp[0]    <= '0;
          first_stamp[1]    <= '0;
        end
        FUNC_MEDIA: begin
          running_prev_size <= running_prev_size + {8'd0, item.payload_size}
                               + 32'(TAG_HDR_LEN);
          if (in_order) begin
            first_stamp[idx] <= base;
          end else begin
            // Stamp went backwards: drop both bases.
            first_stamp[0] <= '0;
            first_stamp[1] <= '0;
          end
        end
        FUNC_DATA: begin
          running_prev_size <= running_prev_size + {8'd0, item.payload_size}
                               + 32'(TAG_HDR_LEN);
        end
        default: begin
        end
      endcase
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    load && item.func == FUNC_START |=>
      running_prev_size == 32'd0 && first_stamp[0] == 32'd0 && first_stamp[1] == 32'd0)
    else $error("stream start did not clear state");

  a_backwards_clears: assert property (@(posedge clk) disable iff (rst)
    load && item.func == FUNC_MEDIA && !in_order |=>
      first_stamp[0] == 32'd0 && first_stamp[1] == 32'd0)
    else $error("out-of-order stamp did not clear bases");

  a_media_ts_bounded: assert property (@(posedge clk) disable iff (rst)
    item.func == FUNC_MEDIA && in_order |-> ts <= item.stamp_in)
    else $error("rebased stamp exceeds input stamp");

endmodule
`default_nettype wire

[sv/flv_tag_header_framer_unit.sv]
// Timing: an accepted request waits in the input register until the byte shifter is free,
// then loads its frame; its first byte is valid right after the load, then one byte per
// cycle while the result port is ready. A tag frame is 15 bytes and a stream start 9;
// the input register takes the next request while bytes still drain.
// Reset: clears the running previous-tag size, both first stamps and all valid flags.
`default_nettype none
module flv_tag_header_framer_unit (
  input wire logic    clk,
  input wire logic    rst,
  flvthf_in_if.sink   item,
  flvthf_out_if.source result
);
  import flvthf_pkg::*;

  in_item_t             in_q;
  logic                 in_valid;
  logic [FRAME_BYTES-1:0][7:0] frame_bytes;
  logic [LEN_W-1:0]     remain;
  frame_t               built;
  logic                 frame_free;
  logic                 load;
  logic                 item_acc;
  logic                 out_acc;

  assign out_acc    = result.valid && result.ready;
  assign frame_free = (remain == '0) || (remain == LEN_W'(1) && result.ready);
  assign load       = in_valid && frame_free;
  assign item.ready = !in_valid || load;
  assign item_acc   = item.valid && item.ready;

  assign result.valid     = remain != '0;
  assign result.out_byte  = frame_bytes[0];
  assign result.last_byte = remain == LEN_W'(1);

  flvthf_build u_build (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .item  (in_q),
    .frame (built)
  );

  // Request holding register.
  always_ff @(posedge clk) begin
    if (item_acc) begin
      in_q.func         <= func_t'(item.func);
      in_q.tag_type     <= item.tag_type;
      in_q.payload_size <= item.payload_size;
      in_q.stamp_in     <= item.stamp_in;
      in_q.has_audio    <= item.has_audio;
      in_q.has_video    <= item.has_video;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_acc) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  // Byte shifter: load a new frame or advance one byte per accepted result.
  always_ff @(posedge clk) begin
    if (load) begin
      frame_bytes <= built.bytes;
    end else if (out_acc) begin
      frame_bytes <= {8'd0, frame_bytes[FRAME_BYTES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (load) begin
      remain <= built.len;
    end else if (out_acc) begin
      remain <= remain - LEN_W'(1);
    end
  end

  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    remain <= LEN_W'(FRAME_BYTES))
    else $error("byte count out of range");

  a_request_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !frame_free |=> in_valid && $stable(in_q))
    else $error("pending request lost");

  a_start_frame: assert property (@(posedge clk) disable iff (rst)
    load && in_q.func == FUNC_START |=>
      frame_bytes[0] == CH_F && remain == LEN_W'(FILE_HDR_LEN))
    else $error("file header not loaded");

  a_tag_frame: assert property (@(posedge clk) disable iff (rst)
    load && (in_q.func == FUNC_MEDIA || in_q.func == FUNC_DATA) |=>
      remain == LEN_W'(FRAME_BYTES))
    else $error("tag frame length wrong");

endmodule
`default_nettype wire

[sim/tb_flv_tag_header_framer_unit.sv]
// Self-checking testbench for the FLV tag header framer: directed and random requests.
`timescale 1ns / 1ps
module tb_flv_tag_header_framer_unit;
  import flvthf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int CALM_ITEMS  = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } exp_byte_t;

  logic clk = 1'b0;
  logic rst;

  flvthf_in_if  req_if ();
  flvthf_out_if res_if ();

  flv_tag_header_framer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (req_if),
    .result (res_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_item_t    req_queue [$];
  exp_byte_t   exp_bytes [$];
  logic [31:0] prev_tag_size;
  logic [31:0] base_stamp [2];
  logic [31:0] stamp_clock;
  int          errors;
  int          n_start, n_media, n_data, n_ignored, n_bytes;
  int          cycles;
  int          req_gap, res_gap;
  logic        calm;

  // Work out the byte stream that one accepted request produces and queue it.
  task automatic predict_frame(input in_item_t r);
    logic [FRAME_BYTES*8-1:0] frame;
    logic [31:0]              ts;
    logic                     idx;
    int                       n;
    exp_byte_t                eb;
    n = 0;
    frame = '0;
    case (r.func)
      FUNC_START: begin
        prev_tag_size = '0;
        base_stamp[0] = '0;
        base_stamp[1] = '0;
        frame = {CH_F, CH_L, CH_V, FLV_VERSION, {5'd0, r.has_audio, 1'b0, r.has_video},
                 8'h00, 8'h00, 8'h00, FILE_HDR_SZ, 48'h0};
        n = FILE_HDR_LEN;
      end
      FUNC_MEDIA, FUNC_DATA: begin
        ts = r.stamp_in;
        if (r.func == FUNC_MEDIA) begin
          idx = r.tag_type[0];
          if (base_stamp[idx] == 32'd0) base_stamp[idx] = r.stamp_in;
          if (r.stamp_in >= base_stamp[idx]) begin
            ts = r.stamp_in - base_stamp[idx];
          end else begin
            // stamp went backwards: forget both bases
            base_stamp[0] = '0;
            base_stamp[1] = '0;
            ts = '0;
          end
        end
        frame = {prev_tag_size, r.tag_type, r.payload_size, ts[23:0], ts[31:24], 24'h0};
        n = FRAME_BYTES;
        prev_tag_size = prev_tag_size + {8'h00, r.payload_size} + TAG_HDR_LEN;
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      eb.data = frame[FRAME_BYTES*8-1-8*i -: 8];
      eb.last = (i == n - 1);
      exp_bytes.push_back(eb);
    end
  endtask

  function automatic void push_req(input func_t f, input logic [7:0] tt,
                                   input logic [23:0] sz, input logic [31:0] st,
                                   input logic a, input logic v);
    in_item_t r;
    r.func         = f;
    r.tag_type     = tt;
    r.payload_size = sz;
    r.stamp_in     = st;
    r.has_audio    = a;
    r.has_video    = v;
    req_queue.push_back(r);
  endfunction

  // Mostly well-formed streams: rising stamps, common tag types; some noise mixed in.
  function automatic in_item_t rand_req();
    in_item_t r;
    int       k;
    case ($urandom_range(0, 3))
      0: r.tag_type = 8'd8;
      1: r.tag_type = 8'd9;
      2: r.tag_type = 8'd18;
      default: r.tag_type = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0: r.payload_size = 24'($urandom_range(0, 1023));
      1: r.payload_size = 24'($urandom);
      2: r.payload_size = 24'hFFFFFF;
      default: r.payload_size = 24'h0;
    endcase
    r.has_audio = 1'($urandom_range(0, 1));
    r.has_video = 1'($urandom_range(0, 1));
    k = $urandom_range(0, 19);
    if (k < 2) r.func = FUNC_START;
    else if (k < 3) r.func = FUNC_NONE;
    else if (k < 13) r.func = FUNC_MEDIA;
    else r.func = FUNC_DATA;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      r.stamp_in = $urandom;
    end else if (k == 1) begin
      r.stamp_in = stamp_clock - 32'($urandom_range(1, 500));
    end else begin
      stamp_clock = stamp_clock + 32'($urandom_range(0, 200));
      r.stamp_in = stamp_clock;
    end
    return r;
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      req_gap <= 0;
      calm <= 1'b0;
    end else begin
      calm <= (req_queue.size() <= CALM_ITEMS);
      if (req_if.valid && req_if.ready) begin
        in_item_t acc;
        acc.func         = func_t'(req_if.func);
        acc.tag_type     = req_if.tag_type;
        acc.payload_size = req_if.payload_size;
        acc.stamp_in     = req_if.stamp_in;
        acc.has_audio    = req_if.has_audio;
        acc.has_video    = req_if.has_video;
        case (acc.func)
          FUNC_START: n_start++;
          FUNC_MEDIA: n_media++;
          FUNC_DATA:  n_data++;
          default:    n_ignored++;
        endcase
        predict_frame(acc);
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap <= req_gap - 1;
          req_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          req_gap <= $urandom_range(0, 14);
          req_if.valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          in_item_t nx;
          nx = req_queue.pop_front();
          req_if.valid        <= 1'b1;
          req_if.func         <= nx.func;
          req_if.tag_type     <= nx.tag_type;
          req_if.payload_size <= nx.payload_size;
          req_if.stamp_in     <= nx.stamp_in;
          req_if.has_audio    <= nx.has_audio;
          req_if.has_video    <= nx.has_video;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and backpressure
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      res_gap <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        exp_byte_t eb;
        if (exp_bytes.size() == 0) begin
          $error("unexpected result byte: out_byte %0h last_byte %0b",
                 res_if.out_byte, res_if.last_byte);
          errors++;
        end else begin
          eb = exp_bytes.pop_front();
          n_bytes++;
          if (res_if.out_byte !== eb.data) begin
            $error("out_byte mismatch: expected %0h actual %0h", eb.data, res_if.out_byte);
            errors++;
          end
          if (res_if.last_byte !== eb.last) begin
            $error("last_byte mismatch: expected %0b actual %0b", eb.last, res_if.last_byte);
            errors++;
          end
        end
      end
      if (res_gap != 0) begin
        res_gap <= res_gap - 1;
        res_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        res_gap <= $urandom_range(0, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cycles = 0;
    errors = 0;
    n_start = 0;
    n_media = 0;
    n_data = 0;
    n_ignored = 0;
    n_bytes = 0;
    prev_tag_size = '0;
    base_stamp[0] = '0;
    base_stamp[1] = '0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_NONE;
    req_if.tag_type = '0;
    req_if.payload_size = '0;
    req_if.stamp_in = '0;
    req_if.has_audio = 1'b0;
    req_if.has_video = 1'b0;
    res_if.ready = 1'b0;
    stamp_clock = 32'($urandom_range(1, 100000));

    // Directed: all header flag values, rebasing cases, field extremes, ignored command.
    push_req(FUNC_MEDIA, 8'd9, 24'd100, 32'd777, 1'b0, 1'b0);
    push_req(FUNC_START, 8'hFF, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
    push_req(FUNC_MEDIA, 8'd9, 24'd0, 32'd1000, 1'b1, 1'b1);
    push_req(FUNC_MEDIA, 8'd8, 24'hFFFFFF, 32'd5000, 1'b0, 1'b0);
    push_req(FUNC_MEDIA, 8'd9, 24'd320, 32'd1500, 1'b0, 1'b1);
    push_req(FUNC_MEDIA, 8'd8, 24'd12, 32'd4000, 1'b1, 1'b0);
    push_req(FUNC_MEDIA, 8'd9, 24'd50, 32'd2000, 1'b0, 1'b0);
    push_req(FUNC_MEDIA, 8'd9, 24'h800001, 32'hFFFFFFFF, 1'b1, 1'b1);
    push_req(FUNC_MEDIA, 8'd8, 24'd1, 32'd0, 1'b0, 1'b0);
    push_req(FUNC_MEDIA, 8'd8, 24'd2, 32'd7, 1'b0, 1'b0);
    push_req(FUNC_MEDIA, 8'hFF, 24'h555555, 32'hAAAAAAAA, 1'b0, 1'b0);
    push_req(FUNC_MEDIA, 8'h00, 24'hAAAAAA, 32'h55555555, 1'b1, 1'b1);
    push_req(FUNC_DATA, 8'd18, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0);
    push_req(FUNC_DATA, 8'd0, 24'd0, 32'd0, 1'b1, 1'b1);
    push_req(FUNC_NONE, 8'd9, 24'h123456, 32'h89ABCDEF, 1'b1, 1'b1);
    push_req(FUNC_DATA, 8'd18, 24'd10, 32'h01000000, 1'b0, 1'b0);
    push_req(FUNC_START, 8'd0, 24'd0, 32'd0, 1'b1, 1'b0);
    push_req(FUNC_MEDIA, 8'd8, 24'd3, 32'd40, 1'b0, 1'b0);
    push_req(FUNC_START, 8'd0, 24'd0, 32'd0, 1'b0, 1'b1);
    push_req(FUNC_START, 8'd0, 24'd0, 32'd0, 1'b0, 1'b0);
    push_req(FUNC_MEDIA, 8'd8, 24'd3, 32'd40, 1'b0, 1'b0);

    for (int i = 0; i < 40; i++) req_queue.push_back(rand_req());
    // Run of maximal tags so the previous-size counter reaches its upper bytes.
    push_req(FUNC_START, 8'd0, 24'd0, 32'd0, 1'b1, 1'b1);
    for (int i = 0; i < 30; i++) begin
      stamp_clock = stamp_clock + 32'($urandom_range(0, 40));
      if (i % 8 == 0) begin
        push_req(FUNC_MEDIA, 8'($urandom_range(8, 9)), 24'hFFFFFF, stamp_clock, 1'b0, 1'b0);
      end else begin
        push_req(FUNC_DATA, 8'($urandom_range(8, 9)), 24'hFFFFFF, stamp_clock, 1'b0, 1'b0);
      end
    end
    for (int i = 0; i < 18; i++) req_queue.push_back(rand_req());

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (req_queue.size() != 0 || req_if.valid || exp_bytes.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (exp_bytes.size() != 0) begin
      $error("%0d expected result bytes never arrived", exp_bytes.size());
      errors++;
    end

    $display("Covered %0d stream starts, %0d media tags, %0d data tags, %0d ignored requests",
             n_start, n_media, n_data, n_ignored);
    $display("Checked %0d output bytes in %0d cycles, %0d mismatches", n_bytes, cycles, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
